>>> rtl/grbm_pkg.sv
`default_nettype none

package grbm_pkg;

    // Pixel and arithmetic widths
    localparam int PIX_W      = 8;
    localparam int NUM_CH     = 4;
    localparam int PIXEL_W    = PIX_W * NUM_CH;
    localparam int WEIGHT_W   = 17;
    localparam int PROD_W     = WEIGHT_W + PIX_W;
    localparam int ACC_W      = 30;
    localparam int FRAC_W     = 16;
    localparam logic [ACC_W-1:0]    ROUND_HALF   = ACC_W'(32768);
    localparam logic [WEIGHT_W-1:0] UNITY_WEIGHT = WEIGHT_W'(65536);

    // Kernel limits
    localparam int RADIUS_W     = 3;
    localparam int CHAN_W       = 3;
    localparam int TAP_W        = 4;
    localparam int CNT_W        = 3;
    localparam int MAX_RADIUS   = 5;
    localparam int MAX_CHANNELS = 4;
    localparam int MAX_OUT      = MAX_RADIUS + 1;
    localparam int NUM_WEIGHTS  = MAX_RADIUS + 1;

    // Stream and configuration layout
    localparam int COL_OUT_W   = 10;
    localparam int TDATA_OUT_W = 48;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = WEIGHT_W;

    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_CENTER = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_DIST5  = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_RADIUS = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 4'd7;

    // Sequencer states
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_CHECK = 5'b00010,
        ST_TAPS  = 5'b00100,
        ST_DRAIN = 5'b01000,
        ST_OUT   = 5'b10000
    } t_state;

    // Control from the sequencer to the multiply-accumulate unit
    typedef struct packed {
        logic clr;
        logic dv;
    } t_mac_ctl;

endpackage

`default_nettype wire

>>> rtl/grbm_ram.sv
`default_nettype none

module grbm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/grbm_mac.sv
`default_nettype none

module grbm_mac (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire grbm_pkg::t_mac_ctl                i_ctl,
    input  wire logic [grbm_pkg::PIXEL_W-1:0]      i_pixel,
    input  wire logic [grbm_pkg::WEIGHT_W-1:0]     i_weight,
    output logic                                   o_busy,
    output logic      [grbm_pkg::PIXEL_W-1:0]      o_result
);

    localparam int QW = grbm_pkg::ACC_W + 1 - grbm_pkg::FRAC_W;

    logic                           r_pv;
    logic [grbm_pkg::PROD_W-1:0]    r_prod [grbm_pkg::NUM_CH];
    logic [grbm_pkg::ACC_W-1:0]     r_acc  [grbm_pkg::NUM_CH];

    assign o_busy = r_pv;

    // Product stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= i_ctl.dv;
        end
    end

    // Multiply each channel by the tap weight, then accumulate
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < grbm_pkg::NUM_CH; i++) begin
            if (i_ctl.dv) begin
                r_prod[i] <= grbm_pkg::PROD_W'(i_weight)
                           * grbm_pkg::PROD_W'(i_pixel[i*grbm_pkg::PIX_W +: grbm_pkg::PIX_W]);
            end
            if (i_ctl.clr) begin
                r_acc[i] <= '0;
            end else if (r_pv) begin
                r_acc[i] <= r_acc[i] + grbm_pkg::ACC_W'(r_prod[i]);
            end
        end
    end

    // Round half up and clamp to 0..255
    always_comb begin
        logic [grbm_pkg::ACC_W:0] sum;
        logic [QW-1:0]            q;
        for (int i = 0; i < grbm_pkg::NUM_CH; i++) begin
            sum = {1'b0, r_acc[i]} + {1'b0, grbm_pkg::ROUND_HALF};
            q   = sum[grbm_pkg::ACC_W:grbm_pkg::FRAC_W];
            o_result[i*grbm_pkg::PIX_W +: grbm_pkg::PIX_W] =
                (q > QW'(255)) ? 8'hFF : q[grbm_pkg::PIX_W-1:0];
        end
    end

endmodule

`default_nettype wire

>>> rtl/gaussian_row_blur_mirror.sv
`default_nettype none

// Channel   Handshake                      Payload
// s_axis    s_axis_tvalid / s_axis_tready  tdata: sample_a..d, tlast: row_end
// m_axis    m_axis_tvalid / m_axis_tready  tdata: blurred_a..d, out_column; tlast: run_last
// cfg       i_cfg_valid / o_cfg_ready      i_cfg_index, i_cfg_data
//
// An item is written to the row store; each output pixel it releases is
// then built tap by tap, paced by the single row memory read port that
// feeds the shared multiply-accumulate one tap per cycle.
// A finished pixel waits in the output register; the next item is taken
// while it waits, but a further pixel stalls until it is taken.
// Reset is synchronous and restores the default kernel (passthrough).

module gaussian_row_blur_mirror #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    // [7:0] sample_a, [15:8] sample_b, [23:16] sample_c, [31:24] sample_d
    input  wire logic [grbm_pkg::PIXEL_W-1:0]         s_axis_tdata,
    input  wire logic                                 s_axis_tlast,
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    // [7:0] blurred_a, [15:8] blurred_b, [23:16] blurred_c, [31:24] blurred_d,
    // [41:32] out_column, [47:42] zero
    output logic      [grbm_pkg::TDATA_OUT_W-1:0]     m_axis_tdata,
    output logic                                      m_axis_tlast,
    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire logic [grbm_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [grbm_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int CW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CNTW   = $clog2(MAX_WIDTH + 1);
    localparam int COLX_W = CNTW + grbm_pkg::COL_OUT_W;

    // Configuration registers
    logic [grbm_pkg::WEIGHT_W-1:0] r_weight [grbm_pkg::NUM_WEIGHTS];
    logic [grbm_pkg::RADIUS_W-1:0] r_radius;
    logic [grbm_pkg::CHAN_W-1:0]   r_chan;

    // Sequencer state
    grbm_pkg::t_state              r_state, n_state;
    logic [CNTW-1:0]               r_wc, n_wc;
    logic [CNTW-1:0]               r_ec, n_ec;
    logic [grbm_pkg::CNT_W-1:0]    r_cnt, n_cnt;
    logic                          r_ending, n_ending;
    logic [grbm_pkg::TAP_W-1:0]    r_tap, n_tap;
    logic [CW-1:0]                 r_pos, n_pos;
    logic                          r_right, n_right;
    logic                          r_v1, n_v1;
    logic [grbm_pkg::RADIUS_W-1:0] r_d1, n_d1;
    logic                          r_out_valid, n_out_valid;
    logic [grbm_pkg::TDATA_OUT_W-1:0] r_out_data, n_out_data;
    logic                          r_out_last, n_out_last;

    // Datapath signals
    logic [grbm_pkg::RADIUS_W-1:0] eff_r;
    logic [grbm_pkg::CHAN_W-1:0]   eff_ch;
    logic [CNTW:0]                 wc_inc;
    logic [CNTW-1:0]               ec_nx;
    logic [grbm_pkg::CNT_W-1:0]    cnt_nx;
    logic                          emit_now;
    logic                          more_next;
    logic                          wr_en;
    logic                          rd_en;
    logic [CW-1:0]                 rd_addr;
    logic [grbm_pkg::PIXEL_W-1:0]  rd_data;
    logic [grbm_pkg::WEIGHT_W-1:0] tap_weight;
    grbm_pkg::t_mac_ctl            mac_ctl;
    logic                          mac_busy;
    logic [grbm_pkg::PIXEL_W-1:0]  mac_result;
    logic [COLX_W-1:0]             col_wide;

    // One mirrored step of the tap walker; returns {direction, position}
    function automatic logic [CW:0] f_step(input logic [CW-1:0] pos,
                                           input logic right,
                                           input logic [CNTW-1:0] width);
        logic          at_end;
        logic [CW:0]   res;
        at_end = (CNTW'(pos) + CNTW'(1)) == width;
        if (right) begin
            res = at_end ? {1'b0, pos} : {1'b1, pos + CW'(1)};
        end else begin
            res = (pos == '0) ? {1'b1, pos} : {1'b0, pos - CW'(1)};
        end
        return res;
    endfunction

    assign s_axis_tready = (r_state == grbm_pkg::ST_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

    // Saturate radius and channel count
    assign eff_r  = (r_radius > grbm_pkg::RADIUS_W'(grbm_pkg::MAX_RADIUS))
                  ? grbm_pkg::RADIUS_W'(grbm_pkg::MAX_RADIUS) : r_radius;
    assign eff_ch = (r_chan == '0) ? grbm_pkg::CHAN_W'(1)
                  : (r_chan > grbm_pkg::CHAN_W'(grbm_pkg::MAX_CHANNELS))
                  ? grbm_pkg::CHAN_W'(grbm_pkg::MAX_CHANNELS) : r_chan;

    // Emit conditions for the current and the following output pixel
    assign wc_inc   = {1'b0, r_wc} + (CNTW+1)'(1);
    assign ec_nx    = r_ec + CNTW'(1);
    assign cnt_nx   = r_cnt + grbm_pkg::CNT_W'(1);
    assign emit_now = (r_cnt < grbm_pkg::CNT_W'(grbm_pkg::MAX_OUT)) && (r_ec < r_wc)
                   && (r_ending || (((CNTW+1)'(r_ec) + (CNTW+1)'(eff_r)) < {1'b0, r_wc}));
    assign more_next = (cnt_nx < grbm_pkg::CNT_W'(grbm_pkg::MAX_OUT)) && (ec_nx < r_wc)
                   && (r_ending || (((CNTW+1)'(ec_nx) + (CNTW+1)'(eff_r)) < {1'b0, r_wc}));

    // Radius zero passes the center pixel through unchanged
    assign tap_weight = (eff_r == '0) ? grbm_pkg::UNITY_WEIGHT : r_weight[r_d1];
    assign col_wide   = COLX_W'(r_ec);

    // Sequencer
    always_comb begin
        logic [CW:0]                 stp;
        logic [CW-1:0]               base_pos;
        logic                        base_right;
        logic [grbm_pkg::TAP_W-1:0]  r_ext;
        n_state     = r_state;
        n_wc        = r_wc;
        n_ec        = r_ec;
        n_cnt       = r_cnt;
        n_ending    = r_ending;
        n_tap       = r_tap;
        n_pos       = r_pos;
        n_right     = r_right;
        n_v1        = 1'b0;
        n_d1        = r_d1;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_out_last  = r_out_last;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = r_ec[CW-1:0];
        mac_ctl.clr = 1'b0;
        mac_ctl.dv  = r_v1;
        r_ext       = grbm_pkg::TAP_W'(eff_r);
        base_pos    = r_pos;
        base_right  = r_right;
        stp         = '0;

        // Drop the held result once taken
        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            grbm_pkg::ST_IDLE: begin
                if (s_axis_tvalid) begin
                    wr_en    = 1'b1;
                    n_wc     = wc_inc[CNTW-1:0];
                    n_ending = s_axis_tlast || (wc_inc >= (CNTW+1)'(MAX_WIDTH));
                    n_cnt    = '0;
                    n_state  = grbm_pkg::ST_CHECK;
                end
            end
            grbm_pkg::ST_CHECK: begin
                if (emit_now) begin
                    mac_ctl.clr = 1'b1;
                    n_tap       = '0;
                    n_state     = grbm_pkg::ST_TAPS;
                end else begin
                    if (r_ending) begin
                        n_wc = '0;
                        n_ec = '0;
                    end
                    n_state = grbm_pkg::ST_IDLE;
                end
            end
            grbm_pkg::ST_TAPS: begin
                // Center first, then walk left, then walk right from the center
                rd_en = 1'b1;
                n_v1  = 1'b1;
                if (r_tap == '0) begin
                    rd_addr = r_ec[CW-1:0];
                    n_pos   = r_ec[CW-1:0];
                    n_right = 1'b0;
                end else begin
                    if (r_tap == r_ext + grbm_pkg::TAP_W'(1)) begin
                        base_pos   = r_ec[CW-1:0];
                        base_right = 1'b1;
                    end
                    stp     = f_step(base_pos, base_right, r_wc);
                    rd_addr = stp[CW-1:0];
                    n_pos   = stp[CW-1:0];
                    n_right = stp[CW];
                end
                n_d1  = (r_tap <= r_ext) ? r_tap[grbm_pkg::RADIUS_W-1:0]
                      : grbm_pkg::RADIUS_W'(r_tap - r_ext);
                n_tap = r_tap + grbm_pkg::TAP_W'(1);
                if (r_tap == {r_ext[grbm_pkg::TAP_W-2:0], 1'b0}) begin
                    n_state = grbm_pkg::ST_DRAIN;
                end
            end
            grbm_pkg::ST_DRAIN: begin
                if (!r_v1 && !mac_busy) begin
                    n_state = grbm_pkg::ST_OUT;
                end
            end
            grbm_pkg::ST_OUT: begin
                // Load the output register when free, mask inactive channels
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_last  = !more_next;
                    n_out_data  = '0;
                    for (int i = 0; i < grbm_pkg::NUM_CH; i++) begin
                        if (grbm_pkg::CHAN_W'(i) < eff_ch) begin
                            n_out_data[i*grbm_pkg::PIX_W +: grbm_pkg::PIX_W] =
                                mac_result[i*grbm_pkg::PIX_W +: grbm_pkg::PIX_W];
                        end
                    end
                    n_out_data[grbm_pkg::PIXEL_W +: grbm_pkg::COL_OUT_W] =
                        col_wide[grbm_pkg::COL_OUT_W-1:0];
                    n_ec    = ec_nx;
                    n_cnt   = cnt_nx;
                    n_state = grbm_pkg::ST_CHECK;
                end
            end
            default: begin
                n_state = grbm_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= grbm_pkg::ST_IDLE;
            r_wc        <= '0;
            r_ec        <= '0;
            r_cnt       <= '0;
            r_ending    <= 1'b0;
            r_tap       <= '0;
            r_v1        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wc        <= n_wc;
            r_ec        <= n_ec;
            r_cnt       <= n_cnt;
            r_ending    <= n_ending;
            r_tap       <= n_tap;
            r_v1        <= n_v1;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_pos      <= n_pos;
        r_right    <= n_right;
        r_d1       <= n_d1;
        r_out_data <= n_out_data;
        r_out_last <= n_out_last;
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight[0] <= grbm_pkg::UNITY_WEIGHT;
            for (int i = 1; i < grbm_pkg::NUM_WEIGHTS; i++) begin
                r_weight[i] <= '0;
            end
            r_radius <= '0;
            r_chan   <= grbm_pkg::CHAN_W'(grbm_pkg::MAX_CHANNELS);
        end else if (i_cfg_valid) begin
            if (i_cfg_index <= grbm_pkg::REG_WEIGHT_DIST5) begin
                r_weight[i_cfg_index[grbm_pkg::RADIUS_W-1:0]] <= i_cfg_data;
            end else if (i_cfg_index == grbm_pkg::REG_KERNEL_RADIUS) begin
                r_radius <= i_cfg_data[grbm_pkg::RADIUS_W-1:0];
            end else if (i_cfg_index == grbm_pkg::REG_CHANNEL_COUNT) begin
                r_chan <= i_cfg_data[grbm_pkg::CHAN_W-1:0];
            end
        end
    end

    // Row store
    grbm_ram #(
        .WIDTH (grbm_pkg::PIXEL_W),
        .DEPTH (MAX_WIDTH)
    ) u_row_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_wc[CW-1:0]),
        .i_wr_data (s_axis_tdata),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Shared multiply-accumulate
    grbm_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (mac_ctl),
        .i_pixel  (rd_data),
        .i_weight (tap_weight),
        .o_busy   (mac_busy),
        .o_result (mac_result)
    );

endmodule

`default_nettype wire
